[src/chunk_header_scanner_defines.svh]
// Assertion macros used by the chunk header scanner checker.
`ifndef CHUNK_HEADER_SCANNER_DEFINES_SVH
`define CHUNK_HEADER_SCANNER_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define CHS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("chunk_header_scanner: same-cycle check failed");

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define CHS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("chunk_header_scanner: next-cycle check failed");

`endif

[src/chs_pkg.sv]
// Types, codes and constants for the chunk header scanner.
package chs_pkg;

  localparam int unsigned HEADER_BYTES = 8;
  localparam logic [31:0] MARK_BIT     = 32'h8000_0000;

  // Scan phases
  localparam logic [1:0] PHASE_HEADER  = 2'd0;
  localparam logic [1:0] PHASE_PAYLOAD = 2'd1;
  localparam logic [1:0] PHASE_DONE    = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_FOUND     = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_TRUNCATED = 2'd2;

  // Configuration register indexes
  localparam logic REG_TARGET_ID     = 1'b0;
  localparam logic REG_BUFFER_LENGTH = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  scan_status;
    logic [31:0] payload_offset;
    logic [31:0] payload_length;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  scan_phase;
    logic [2:0]  header_byte_index;
    logic [31:0] id_shift;
    logic [31:0] size_shift;
    logic [31:0] payload_remaining;
    logic [32:0] byte_position;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    scan_phase:        PHASE_HEADER,
    header_byte_index: 3'd0,
    id_shift:          32'd0,
    size_shift:        32'd0,
    payload_remaining: 32'd0,
    byte_position:     33'd0
  };

endpackage

[src/chunk_header_scanner.sv]
// Chunk header scanner: walks a byte stream of id/size chunks and reports the target chunk.
//
// One byte is taken per transfer and the block accepts a byte in every cycle
// in which in_stall is low. Each byte passes through one step of combinational
// logic (a shift, a position counter and three 34-bit add/compares) between the
// scan state registers and a single output register, so a decision appears on
// out_ in the cycle after the byte that caused it. The output register keeps the
// input side flowing while a result waits: in_stall rises only when a result is
// held and out_stall is high. At most one result comes per buffer: found with
// the payload offset and size, truncated when a chunk runs past
// buffer_length, or not found when fewer than 8 bytes remain at a header
// start. After a decision the remaining bytes are swallowed until a byte with
// start_of_buffer set restarts the scan. Registers are written through
// cfg_we/cfg_index/cfg_wdata and take effect from the next byte.
module chunk_header_scanner (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  chs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output chs_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_wdata
);

  chs_pkg::scan_state_t st_r;
  chs_pkg::scan_state_t st_nxt;
  chs_pkg::out_item_t   out_data_r;
  chs_pkg::out_item_t   res;
  logic                 out_valid_r;
  logic                 emit;
  logic                 in_take;
  logic [30:0]          target_id_r;
  logic [31:0]          buffer_length_r;

  // Input stalls only while a finished result is held back downstream.
  assign in_stall  = out_valid_r & out_stall;
  assign in_take   = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  chs_step u_step (
    .st            (st_r),
    .item          (in_data),
    .target_id     (target_id_r),
    .buffer_length (buffer_length_r),
    .st_nxt        (st_nxt),
    .emit          (emit),
    .res           (res)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_id_r     <= '0;
      buffer_length_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        chs_pkg::REG_TARGET_ID:     target_id_r     <= cfg_wdata[30:0];
        chs_pkg::REG_BUFFER_LENGTH: buffer_length_r <= cfg_wdata;
      endcase
    end
  end

  // Scan state advances once per accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= chs_pkg::SCAN_RESET;
    end else if (in_take) begin
      st_r <= st_nxt;
    end
  end

  // Output register: loads a new decision, drops valid once transferred
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take && emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && emit) begin
      out_data_r <= res;
    end
  end

endmodule

[src/chs_step.sv]
// Per-byte next-state and decision logic of the chunk header scanner.
module chs_step (
  input  chs_pkg::scan_state_t st,
  input  chs_pkg::in_item_t    item,
  input  logic [30:0]          target_id,
  input  logic [31:0]          buffer_length,
  output chs_pkg::scan_state_t st_nxt,
  output logic                 emit,
  output chs_pkg::out_item_t   res
);

  chs_pkg::scan_state_t cur;
  logic [32:0] pos_inc;
  logic [31:0] id_upd;
  logic [31:0] size_upd;
  logic        wont_fit_now;
  logic        wont_fit_next;
  logic        truncated;

  always_comb begin
    cur = item.start_of_buffer ? chs_pkg::SCAN_RESET : st;
    pos_inc = cur.byte_position + 33'd1;
    id_upd   = cur.header_byte_index[2] ? cur.id_shift
                                        : {item.data_byte, cur.id_shift[31:8]};
    size_upd = cur.header_byte_index[2] ? {item.data_byte, cur.size_shift[31:8]}
                                        : cur.size_shift;
    // header start at pos: pos + 8 > length
    wont_fit_now  = ({1'b0, cur.byte_position} + 34'(chs_pkg::HEADER_BYTES))
                    > {2'b00, buffer_length};
    // header start at pos + 1: pos + 9 > length
    wont_fit_next = ({1'b0, cur.byte_position} + 34'(chs_pkg::HEADER_BYTES + 1))
                    > {2'b00, buffer_length};
    // (pos + 1) + size > length  <=>  pos + size >= length
    truncated     = ({1'b0, cur.byte_position} + {2'b00, size_upd})
                    >= {2'b00, buffer_length};
  end

  always_comb begin
    st_nxt = cur;
    emit   = 1'b0;
    res.scan_status    = chs_pkg::ST_NOT_FOUND;
    res.payload_offset = 32'd0;
    res.payload_length = 32'd0;
    unique case (cur.scan_phase)
      chs_pkg::PHASE_HEADER: begin
        if (cur.header_byte_index == 3'd0 && wont_fit_now) begin
          emit = 1'b1;
        end else begin
          st_nxt.byte_position     = pos_inc;
          st_nxt.id_shift          = id_upd;
          st_nxt.size_shift        = size_upd;
          st_nxt.header_byte_index = cur.header_byte_index + 3'd1;
          if (cur.header_byte_index == 3'd7) begin
            if (truncated) begin
              emit = 1'b1;
              res.scan_status = chs_pkg::ST_TRUNCATED;
            end else if ((id_upd & ~chs_pkg::MARK_BIT) == {1'b0, target_id}) begin
              emit = 1'b1;
              res.scan_status    = chs_pkg::ST_FOUND;
              res.payload_offset = pos_inc[31:0];
              res.payload_length = size_upd;
            end else if (size_upd != 32'd0) begin
              st_nxt.payload_remaining = size_upd;
              st_nxt.scan_phase        = chs_pkg::PHASE_PAYLOAD;
            end else if (wont_fit_next) begin
              emit = 1'b1;
            end
          end
        end
      end
      chs_pkg::PHASE_PAYLOAD: begin
        st_nxt.byte_position     = pos_inc;
        st_nxt.payload_remaining = cur.payload_remaining - 32'd1;
        if (cur.payload_remaining == 32'd1) begin
          st_nxt.scan_phase        = chs_pkg::PHASE_HEADER;
          st_nxt.header_byte_index = 3'd0;
          emit = wont_fit_next;
        end
      end
      default: begin
        // decided: bytes ignored until the next start flag
      end
    endcase
    if (emit) st_nxt.scan_phase = chs_pkg::PHASE_DONE;
  end

endmodule

[src/chs_checker.sv]
// Port-level checker for the chunk header scanner, with its bind.
`include "chunk_header_scanner_defines.svh"

module chs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input chs_pkg::out_item_t out_data
);

  logic miss_report;
  logic miss_fields_zero;

  assign miss_report      = out_valid && out_data.scan_status != chs_pkg::ST_FOUND;
  assign miss_fields_zero = out_data.payload_offset == 32'd0 &&
                            out_data.payload_length == 32'd0;

  `CHS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `CHS_ASSERT_SAME(a_stall_backpressure, out_valid && out_stall, in_stall)
  `CHS_ASSERT_SAME(a_status_code, out_valid, out_data.scan_status <= chs_pkg::ST_TRUNCATED)
  `CHS_ASSERT_SAME(a_miss_zero_fields, miss_report, miss_fields_zero)

endmodule

bind chunk_header_scanner chs_checker u_chs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
